/* src/svte_pkg.sv */
// ----------------------------------------------------------------------------
// svte_pkg
// Shared widths, stream layout, register indexes and payload types for the
// shadow volume triangle emitter.
// ----------------------------------------------------------------------------
package svte_pkg;

  localparam int INDEX_BITS = 15;
  localparam int COORD_W    = 16;
  localparam int CORNER_W   = 16;
  localparam int REG_W      = 16;
  localparam int REG_IDX_W  = 2;

  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NORM_W     = PROD_W + 1;
  localparam int LPROD_W    = NORM_W + REG_W;
  localparam int DOT_W      = LPROD_W + 2;

  localparam int TRIS_PER_RUN = 8;
  localparam int BEAT_W       = $clog2(TRIS_PER_RUN);

  // input beat layout, lowest bits first
  localparam int IN_IDX_A  = 0;
  localparam int IN_IDX_B  = IN_IDX_A + INDEX_BITS;
  localparam int IN_IDX_C  = IN_IDX_B + INDEX_BITS;
  localparam int IN_COORD  = IN_IDX_C + INDEX_BITS;
  localparam int IN_BITS   = IN_COORD + 9 * COORD_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_BITS  = 3 * CORNER_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [REG_IDX_W-1:0] REG_LIGHT_X      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Z      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd3;

  localparam logic signed [REG_W-1:0] LIGHT_Z_RESET = 16'sd16384;

  // position of each triangle within a run
  localparam logic [BEAT_W-1:0] BEAT_FAR_CAP   = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_NEAR_CAP  = 3'd1;
  localparam logic [BEAT_W-1:0] BEAT_EDGE0_LO  = 3'd2;
  localparam logic [BEAT_W-1:0] BEAT_EDGE0_HI  = 3'd3;
  localparam logic [BEAT_W-1:0] BEAT_EDGE1_LO  = 3'd4;
  localparam logic [BEAT_W-1:0] BEAT_EDGE1_HI  = 3'd5;
  localparam logic [BEAT_W-1:0] BEAT_EDGE2_LO  = 3'd6;
  localparam logic [BEAT_W-1:0] BEAT_EDGE2_HI  = 3'd7;

  typedef logic [INDEX_BITS-1:0]    index_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [REG_W-1:0]   light_t;

  typedef struct packed {
    index_t a;
    index_t b;
    index_t c;
  } tri_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } normal_t;

  typedef struct packed {
    light_t x;
    light_t y;
    light_t z;
  } light_dir_t;

endpackage

/* src/svte_normal.sv */
// ----------------------------------------------------------------------------
// svte_normal
// Three-stage face normal pipeline: edge vectors, cross products, normal.
// ----------------------------------------------------------------------------
module svte_normal
  import svte_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tri_idx_t in_idx,
  input  vec_t     in_a,
  input  vec_t     in_b,
  input  vec_t     in_c,
  output logic     out_valid,
  input  logic     out_ready,
  output tri_idx_t out_idx,
  output normal_t  out_n
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  tri_idx_t idx1, idx2;
  logic signed [DIFF_W-1:0] ux, uy, uz, wx, wy, wz;
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // stage 1: edge vectors b-a and c-a
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      idx1 <= in_idx;
      ux   <= DIFF_W'(in_b.x) - DIFF_W'(in_a.x);
      uy   <= DIFF_W'(in_b.y) - DIFF_W'(in_a.y);
      uz   <= DIFF_W'(in_b.z) - DIFF_W'(in_a.z);
      wx   <= DIFF_W'(in_c.x) - DIFF_W'(in_a.x);
      wy   <= DIFF_W'(in_c.y) - DIFF_W'(in_a.y);
      wz   <= DIFF_W'(in_c.z) - DIFF_W'(in_a.z);
    end
  end

  // stage 2: cross product terms
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      idx2 <= idx1;
      p_yz <= PROD_W'(uy) * PROD_W'(wz);
      p_zy <= PROD_W'(uz) * PROD_W'(wy);
      p_zx <= PROD_W'(uz) * PROD_W'(wx);
      p_xz <= PROD_W'(ux) * PROD_W'(wz);
      p_xy <= PROD_W'(ux) * PROD_W'(wy);
      p_yx <= PROD_W'(uy) * PROD_W'(wx);
    end
  end

  // stage 3: normal
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      out_idx  <= idx2;
      out_n.x  <= NORM_W'(p_yz) - NORM_W'(p_zy);
      out_n.y  <= NORM_W'(p_zx) - NORM_W'(p_xz);
      out_n.z  <= NORM_W'(p_xy) - NORM_W'(p_yx);
    end
  end

  assign out_valid = v3;

endmodule

/* src/svte_facing.sv */
// ----------------------------------------------------------------------------
// svte_facing
// Two-stage light test: normal times light, then sign of the sum.
// Back-facing triangles are dropped here.
// ----------------------------------------------------------------------------
module svte_facing
  import svte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  light_dir_t light,
  input  logic       in_valid,
  output logic       in_ready,
  input  tri_idx_t   in_idx,
  input  normal_t    in_n,
  output logic       out_valid,
  input  logic       out_ready,
  output tri_idx_t   out_idx
);

  logic v4, v5, facing;
  logic r4, r5;
  tri_idx_t idx4;
  logic signed [LPROD_W-1:0] m_x, m_y, m_z;
  logic signed [DOT_W-1:0]   dot;

  assign r5       = !v5 || !facing || out_ready;
  assign r4       = !v4 || r5;
  assign in_ready = r4;

  assign dot = DOT_W'(m_x) + DOT_W'(m_y) + DOT_W'(m_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && in_valid) begin
      idx4 <= in_idx;
      m_x  <= LPROD_W'(in_n.x) * LPROD_W'(light.x);
      m_y  <= LPROD_W'(in_n.y) * LPROD_W'(light.y);
      m_z  <= LPROD_W'(in_n.z) * LPROD_W'(light.z);
    end
  end

  // zero counts as facing
  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      out_idx <= idx4;
      facing  <= !dot[DOT_W-1];
    end
  end

  assign out_valid = v5 && facing;

endmodule

/* src/svte_emit.sv */
// ----------------------------------------------------------------------------
// svte_emit
// Run sequencer: holds one facing triangle and sends its eight shadow
// volume triangles, far cap first.
// ----------------------------------------------------------------------------
module svte_emit
  import svte_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [REG_W-1:0]    vertex_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  tri_idx_t            in_idx,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CORNER_W-1:0] out_first,
  output logic [CORNER_W-1:0] out_second,
  output logic [CORNER_W-1:0] out_third,
  output logic                out_last
);

  logic busy;
  logic [BEAT_W-1:0] beat;
  logic [CORNER_W-1:0] s0, s1, s2, e0, e1, e2;
  logic last_beat;

  assign last_beat = (beat == BEAT_EDGE2_HI);
  assign in_ready  = !busy || (out_ready && last_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= BEAT_FAR_CAP;
    end else if (in_ready) begin
      busy <= in_valid;
      beat <= BEAT_FAR_CAP;
    end else if (out_ready) begin
      beat <= beat + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0 <= CORNER_W'(in_idx.a);
      s1 <= CORNER_W'(in_idx.b);
      s2 <= CORNER_W'(in_idx.c);
      e0 <= CORNER_W'(in_idx.a) + vertex_count;
      e1 <= CORNER_W'(in_idx.b) + vertex_count;
      e2 <= CORNER_W'(in_idx.c) + vertex_count;
    end
  end

  always_comb begin
    case (beat)
      BEAT_FAR_CAP:  begin out_first = e2; out_second = e1; out_third = e0; end
      BEAT_NEAR_CAP: begin out_first = s0; out_second = s1; out_third = s2; end
      BEAT_EDGE0_LO: begin out_first = s0; out_second = e0; out_third = s1; end
      BEAT_EDGE0_HI: begin out_first = s1; out_second = e0; out_third = e1; end
      BEAT_EDGE1_LO: begin out_first = s1; out_second = e1; out_third = s2; end
      BEAT_EDGE1_HI: begin out_first = s2; out_second = e1; out_third = e2; end
      BEAT_EDGE2_LO: begin out_first = s2; out_second = e2; out_third = s0; end
      BEAT_EDGE2_HI: begin out_first = s0; out_second = e2; out_third = e0; end
      default:       begin out_first = s0; out_second = s1; out_third = s2; end
    endcase
  end

  assign out_valid = busy;
  assign out_last  = last_beat;

endmodule

/* src/shadow_volume_triangle_emit_core.sv */
// ----------------------------------------------------------------------------
// shadow_volume_triangle_emit_core
// Stencil shadow volume extrusion: light-facing test and index emission.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one triangle per beat: three vertex indices and three Q8.8
//   positions. m_* carries shadow triangles as index triples; m_tlast marks
//   the eighth triangle of a run. A triangle whose normal points away from
//   the light (negative dot product) yields no beats at all.
//   cfg_we/cfg_index/cfg_data write the light direction (Q1.14) and the
//   vertex count; write them only while the block is empty.
// Path: an input beat passes the normal and facing stages, then the sequencer.
// Throughput: the five-stage normal and facing pipeline takes one triangle
//   per cycle while nothing stalls it; the run sequencer sends one output
//   beat per cycle while m_tready is high. Back-facing triangles send none.
// Stall: when m_tready is low the sequencer holds its beat and the pipeline
//   fills up behind it; s_tready drops only once every stage is occupied.
// Reset: rst clears all valid bits and loads the light to +z, vertex
//   count 0. s_tready is high the cycle after reset.
// ----------------------------------------------------------------------------
module shadow_volume_triangle_emit_core
  import svte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // idx_a, idx_b, idx_c, ax, ay, az, bx, by_coord, bz, cx, cy, cz, zero pad
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // corner_first, corner_second, corner_third
  output logic [OUT_W-1:0]     m_tdata,
  // last_of_run
  output logic                 m_tlast
);

  light_dir_t light;
  logic [REG_W-1:0] vertex_count;

  tri_idx_t in_idx;
  vec_t in_a, in_b, in_c;

  logic nrm_valid, nrm_ready;
  tri_idx_t nrm_idx;
  normal_t nrm_n;

  logic fac_valid, fac_ready;
  tri_idx_t fac_idx;

  logic [CORNER_W-1:0] c_first, c_second, c_third;

  always_ff @(posedge clk) begin
    if (rst) begin
      light.x      <= '0;
      light.y      <= '0;
      light.z      <= LIGHT_Z_RESET;
      vertex_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_X:      light.x      <= cfg_data;
        REG_LIGHT_Y:      light.y      <= cfg_data;
        REG_LIGHT_Z:      light.z      <= cfg_data;
        REG_VERTEX_COUNT: vertex_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_idx.a = s_tdata[IN_IDX_A +: INDEX_BITS];
  assign in_idx.b = s_tdata[IN_IDX_B +: INDEX_BITS];
  assign in_idx.c = s_tdata[IN_IDX_C +: INDEX_BITS];
  assign in_a.x   = s_tdata[IN_COORD + 0 * COORD_W +: COORD_W];
  assign in_a.y   = s_tdata[IN_COORD + 1 * COORD_W +: COORD_W];
  assign in_a.z   = s_tdata[IN_COORD + 2 * COORD_W +: COORD_W];
  assign in_b.x   = s_tdata[IN_COORD + 3 * COORD_W +: COORD_W];
  assign in_b.y   = s_tdata[IN_COORD + 4 * COORD_W +: COORD_W];
  assign in_b.z   = s_tdata[IN_COORD + 5 * COORD_W +: COORD_W];
  assign in_c.x   = s_tdata[IN_COORD + 6 * COORD_W +: COORD_W];
  assign in_c.y   = s_tdata[IN_COORD + 7 * COORD_W +: COORD_W];
  assign in_c.z   = s_tdata[IN_COORD + 8 * COORD_W +: COORD_W];

  svte_normal u_normal (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_idx    (in_idx),
    .in_a      (in_a),
    .in_b      (in_b),
    .in_c      (in_c),
    .out_valid (nrm_valid),
    .out_ready (nrm_ready),
    .out_idx   (nrm_idx),
    .out_n     (nrm_n)
  );

  svte_facing u_facing (
    .clk       (clk),
    .rst       (rst),
    .light     (light),
    .in_valid  (nrm_valid),
    .in_ready  (nrm_ready),
    .in_idx    (nrm_idx),
    .in_n      (nrm_n),
    .out_valid (fac_valid),
    .out_ready (fac_ready),
    .out_idx   (fac_idx)
  );

  svte_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .in_valid     (fac_valid),
    .in_ready     (fac_ready),
    .in_idx       (fac_idx),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_first    (c_first),
    .out_second   (c_second),
    .out_third    (c_third),
    .out_last     (m_tlast)
  );

  assign m_tdata = OUT_W'({c_third, c_second, c_first});

endmodule

/* src/svte_checker.sv */
// ----------------------------------------------------------------------------
// svte_checker
// Port-level checks for the shadow volume triangle emitter.
// ----------------------------------------------------------------------------
module svte_checker
  import svte_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // a run never breaks before its last beat
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("run ended without last beat");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind shadow_volume_triangle_emit_core svte_checker u_svte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
